// ===== sv/fvsp_pkg.sv =====
`timescale 1ns / 1ps

package fvsp_pkg;

    typedef enum logic [1:0] {
        FUNC_MEM_WRITE  = 2'd0,
        FUNC_SLOT_WRITE = 2'd1,
        FUNC_CHANNEL    = 2'd2,
        FUNC_TICK       = 2'd3
    } func_t;

    typedef struct packed {
        func_t       func;
        logic [1:0]  channel;
        logic        enable_given;
        logic        enable_value;
        logic        restart;
        logic        sample_given;
        logic [3:0]  slot;
        logic [23:0] pitch_step;
        logic [15:0] address;
        logic [7:0]  byte_value;
        logic [15:0] length;
        logic [15:0] loop_point;
    } cmd_t;

    typedef struct packed {
        logic [7:0] voice_a;
        logic [7:0] voice_b;
        logic [7:0] voice_c;
        logic [7:0] voice_d;
        logic [2:0] active_count;
    } res_t;

    localparam logic [7:0] SILENCE      = 8'd128;
    localparam int         OUT_VOICES   = 4;
    // result queue: two entries, pointers wrap in one bit
    localparam int         RES_DEPTH    = 2;
    localparam int         RES_PTR_BITS = 1;
    localparam int         RES_CNT_BITS = 2;

endpackage

// ===== sv/fvsp_ram.sv =====
`timescale 1ns / 1ps

module fvsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                           wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr_a,
    output logic [WIDTH-1:0]                           rd_data_a,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]                           rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// ===== sv/fvsp_result_queue.sv =====
`timescale 1ns / 1ps

module fvsp_result_queue
    import fvsp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  res_t push_data,
    output logic valid,
    input  logic ready,
    output res_t data
);

    res_t                    entry_reg [RES_DEPTH];
    logic [RES_PTR_BITS-1:0] wr_ptr_reg;
    logic [RES_PTR_BITS-1:0] rd_ptr_reg;
    logic [RES_CNT_BITS-1:0] count_reg;
    logic                    pop;

    assign valid = (count_reg != '0);
    assign data  = entry_reg[rd_ptr_reg];
    assign pop   = valid && ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |-> (count_reg < RES_CNT_BITS'(RES_DEPTH)))
        else $error("result queue overflow");

endmodule

// ===== sv/four_voice_sample_player_core.sv =====
`timescale 1ns / 1ps
// Channel   Signals                           Transfer
// cmd       cmd_valid / cmd_ready / cmd       one command (cmd_t) per transaction
// res       res_valid / res_ready / res       one tick result (res_t) per transaction
//
// A memory write, descriptor write or channel update issues as a single op; an
// output tick issues one voice a cycle unless an interlock holds it, each voice
// doing one slot-table read and a dual-port sample-memory read. Results pass
// the read and write-back stages into the result queue. Issue holds while an
// op still in flight writes the voice it needs. Reset clears voices and the
// slot-table valid bits at once; no clearing pass. Up to two tick results
// queue on res while res_ready is low; cmd_ready drops once both are taken.

module four_voice_sample_player_core
    import fvsp_pkg::*;
#(
    parameter int VOICES        = 4,
    parameter int SLOTS         = 16,
    parameter int MEM_ADDR_BITS = 16,
    parameter int FRAC_BITS     = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_ready,
    input  cmd_t cmd,
    output logic res_valid,
    input  logic res_ready,
    output res_t res
);

    localparam int VIDX_BITS     = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int SLOT_BITS     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int POS_INT_BITS  = 32 - FRAC_BITS;
    localparam int MEM_DEPTH     = 1 << MEM_ADDR_BITS;
    localparam int SLOT_WORD     = 48;
    localparam int CNT_BITS      = $clog2(VOICES + 1);

    typedef struct packed {
        logic                 writes_voice;
        logic [VIDX_BITS-1:0] voice;
        logic                 last;
        cmd_t                 cmd;
    } op_t;

    // voice state
    logic [VOICES-1:0]    voice_en_reg;
    logic [VOICES-1:0]    voice_en_next;
    logic [31:0]          voice_pos_reg   [VOICES];
    logic [31:0]          voice_pos_next  [VOICES];
    logic [SLOT_BITS-1:0] voice_slot_reg  [VOICES];
    logic [SLOT_BITS-1:0] voice_slot_next [VOICES];
    logic [23:0]          voice_step_reg  [VOICES];
    logic [23:0]          voice_step_next [VOICES];

    // issue stage
    logic                 hold_valid_reg;
    cmd_t                 hold_reg;
    logic [VIDX_BITS-1:0] vidx_reg;
    logic                 iss_tick;
    logic                 iss_ch_ok;
    logic [VIDX_BITS-1:0] iss_voice;
    logic                 iss_writes;
    logic                 iss_conflict;
    logic                 iss_go;
    logic                 iss_vlast;
    logic                 iss_last;
    logic                 cmd_acc;
    logic [1:0]           reserved_reg;
    logic                 credit_ok;

    // slot table
    logic [SLOTS-1:0]     slot_valid_reg;
    logic                 slot_rd_valid_reg;
    logic                 iss_slot_ok;
    logic [SLOT_BITS-1:0] iss_slot_idx;
    logic [SLOT_BITS-1:0] slot_rd_addr;
    logic                 slot_we;
    logic [SLOT_WORD-1:0] slot_wr_data;
    logic [SLOT_WORD-1:0] slot_rd_data;

    // read stage
    logic                    p1_valid_reg;
    op_t                     p1_op_reg;
    logic [SLOT_WORD-1:0]    p1_slot_word;
    logic [15:0]             p1_start;
    logic [15:0]             p1_len;
    logic [15:0]             p1_loop;
    logic [31:0]             p1_pos;
    logic [POS_INT_BITS-1:0] p1_pint;
    logic [31:0]             p1_sum_a;
    logic [31:0]             p1_sum_b;
    logic [32:0]             p1_run;
    logic [32:0]             p1_jump;
    logic                    mem_we;
    logic [7:0]              mem_rd_a;
    logic [7:0]              mem_rd_b;

    // write-back stage
    logic        p2_valid_reg;
    op_t         p2_op_reg;
    logic        p2_en_reg;
    logic        p2_past_end_reg;
    logic        p2_loop_ok_reg;
    logic        p2_switch_ok_reg;
    logic [31:0] p2_run_reg;
    logic [31:0] p2_jump_reg;
    logic        p2_tick;
    logic [7:0]  tick_byte;
    logic [7:0]  acc_reg  [OUT_VOICES];
    logic [7:0]  acc_next [OUT_VOICES];
    logic [CNT_BITS-1:0] active;
    logic        res_push;
    res_t        res_push_data;

    // ---------------- issue ----------------
    assign iss_tick     = (hold_reg.func == FUNC_TICK);
    assign iss_ch_ok    = (32'(hold_reg.channel) < VOICES);
    assign iss_voice    = iss_tick ? vidx_reg : VIDX_BITS'(hold_reg.channel);
    assign iss_writes   = iss_tick || ((hold_reg.func == FUNC_CHANNEL) && iss_ch_ok);
    // hold while an op ahead still has to write this voice back
    assign iss_conflict = iss_writes &&
        ((p1_valid_reg && p1_op_reg.writes_voice && (p1_op_reg.voice == iss_voice)) ||
         (p2_valid_reg && p2_op_reg.writes_voice && (p2_op_reg.voice == iss_voice)));
    assign iss_go       = hold_valid_reg && !iss_conflict;
    assign iss_vlast    = (vidx_reg == VIDX_BITS'(VOICES - 1));
    assign iss_last     = iss_go && (!iss_tick || iss_vlast);
    assign credit_ok    = (reserved_reg < 2'(RES_DEPTH));
    assign cmd_ready    = credit_ok && (!hold_valid_reg || iss_last);
    assign cmd_acc      = cmd_valid && cmd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            vidx_reg       <= '0;
            reserved_reg   <= '0;
        end
        else
        begin
            if (cmd_acc)
            begin
                hold_valid_reg <= 1'b1;
                vidx_reg       <= '0;
            end
            else if (iss_last)
            begin
                hold_valid_reg <= 1'b0;
            end
            else if (iss_go)
            begin
                vidx_reg <= vidx_reg + 1'b1;
            end

            if ((cmd_acc && (cmd.func == FUNC_TICK)) && !(res_valid && res_ready))
            begin
                reserved_reg <= reserved_reg + 1'b1;
            end
            else if (!(cmd_acc && (cmd.func == FUNC_TICK)) && (res_valid && res_ready))
            begin
                reserved_reg <= reserved_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_acc)
        begin
            hold_reg <= cmd;
        end
    end

    // ---------------- slot table ----------------
    assign iss_slot_ok  = (32'(hold_reg.slot) < SLOTS);
    assign iss_slot_idx = SLOT_BITS'(hold_reg.slot);
    assign slot_rd_addr = iss_tick ? voice_slot_reg[iss_voice] :
                          (iss_slot_ok ? iss_slot_idx : '0);
    assign slot_we      = iss_go && (hold_reg.func == FUNC_SLOT_WRITE) && iss_slot_ok;
    assign slot_wr_data = {hold_reg.address, hold_reg.length, hold_reg.loop_point};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg    <= '0;
            slot_rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (slot_we)
            begin
                slot_valid_reg[iss_slot_idx] <= 1'b1;
            end
            slot_rd_valid_reg <= slot_valid_reg[slot_rd_addr];
        end
    end

    fvsp_ram #(
        .WIDTH (SLOT_WORD),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk       (clk),
        .we        (slot_we),
        .wr_addr   (iss_slot_idx),
        .wr_data   (slot_wr_data),
        .rd_addr_a (slot_rd_addr),
        .rd_data_a (slot_rd_data),
        .rd_addr_b (slot_rd_addr),
        .rd_data_b ()
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= iss_go;
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_op_reg.writes_voice <= iss_writes;
        p1_op_reg.voice        <= iss_voice;
        p1_op_reg.last         <= iss_vlast;
        p1_op_reg.cmd          <= hold_reg;
    end

    // ---------------- read stage ----------------
    // a slot never written reads as zero
    assign p1_slot_word = slot_rd_valid_reg ? slot_rd_data : '0;
    assign p1_start     = p1_slot_word[47:32];
    assign p1_len       = p1_slot_word[31:16];
    assign p1_loop      = p1_slot_word[15:0];
    assign p1_pos       = voice_pos_reg[p1_op_reg.voice];
    assign p1_pint      = p1_pos[31:FRAC_BITS];
    assign p1_sum_a     = 32'(p1_start) + 32'(p1_pint);
    assign p1_sum_b     = 32'(p1_start) + 32'(p1_loop);
    assign p1_run       = {1'b0, p1_pos} + 33'(voice_step_reg[p1_op_reg.voice]);
    assign p1_jump      = {1'b0, (32'(p1_loop) << FRAC_BITS)} +
                          33'(voice_step_reg[p1_op_reg.voice]);
    assign mem_we       = p1_valid_reg && (p1_op_reg.cmd.func == FUNC_MEM_WRITE);

    // port A reads the byte at the position, port B the byte at the loop point
    fvsp_ram #(
        .WIDTH (8),
        .DEPTH (MEM_DEPTH)
    ) u_sample_ram (
        .clk       (clk),
        .we        (mem_we),
        .wr_addr   (MEM_ADDR_BITS'(p1_op_reg.cmd.address)),
        .wr_data   (p1_op_reg.cmd.byte_value),
        .rd_addr_a (p1_sum_a[MEM_ADDR_BITS-1:0]),
        .rd_data_a (mem_rd_a),
        .rd_addr_b (p1_sum_b[MEM_ADDR_BITS-1:0]),
        .rd_data_b (mem_rd_b)
    );

    always_ff @(posedge clk)
    begin
        p2_op_reg        <= p1_op_reg;
        p2_en_reg        <= voice_en_reg[p1_op_reg.voice];
        p2_past_end_reg  <= (32'(p1_pint) >= 32'(p1_len));
        p2_loop_ok_reg   <= (p1_loop < p1_len);
        p2_switch_ok_reg <= p1_op_reg.cmd.sample_given &&
                            (32'(p1_op_reg.cmd.slot) < SLOTS) && (p1_len != 16'd0);
        // saturate the position
        p2_run_reg       <= p1_run[32] ? 32'hFFFF_FFFF : p1_run[31:0];
        p2_jump_reg      <= p1_jump[32] ? 32'hFFFF_FFFF : p1_jump[31:0];
    end

    // ---------------- write-back stage ----------------
    assign p2_tick = (p2_op_reg.cmd.func == FUNC_TICK);

    always_comb
    begin
        voice_en_next   = voice_en_reg;
        voice_pos_next  = voice_pos_reg;
        voice_slot_next = voice_slot_reg;
        voice_step_next = voice_step_reg;
        tick_byte       = SILENCE;
        if (p2_valid_reg && p2_op_reg.writes_voice)
        begin
            if (p2_tick)
            begin
                if (p2_en_reg)
                begin
                    if (p2_past_end_reg || (mem_rd_a == 8'd0))
                    begin
                        if (p2_loop_ok_reg)
                        begin
                            tick_byte                       = mem_rd_b;
                            voice_pos_next[p2_op_reg.voice] = p2_jump_reg;
                        end
                        else
                        begin
                            voice_en_next[p2_op_reg.voice] = 1'b0;
                        end
                    end
                    else
                    begin
                        tick_byte                       = mem_rd_a;
                        voice_pos_next[p2_op_reg.voice] = p2_run_reg;
                    end
                end
            end
            else
            begin
                if (p2_op_reg.cmd.enable_given)
                begin
                    voice_en_next[p2_op_reg.voice] = p2_op_reg.cmd.enable_value;
                    if (!p2_op_reg.cmd.enable_value)
                    begin
                        voice_pos_next[p2_op_reg.voice] = '0;
                    end
                end
                if (p2_op_reg.cmd.restart)
                begin
                    voice_pos_next[p2_op_reg.voice] = '0;
                end
                if (p2_switch_ok_reg)
                begin
                    voice_slot_next[p2_op_reg.voice] = SLOT_BITS'(p2_op_reg.cmd.slot);
                    voice_pos_next[p2_op_reg.voice]  = '0;
                end
                voice_step_next[p2_op_reg.voice] = p2_op_reg.cmd.pitch_step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            voice_en_reg <= '0;
            for (int i = 0; i < VOICES; i++)
            begin
                voice_pos_reg[i]  <= '0;
                voice_slot_reg[i] <= '0;
                voice_step_reg[i] <= '0;
            end
        end
        else
        begin
            voice_en_reg    <= voice_en_next;
            voice_pos_reg   <= voice_pos_next;
            voice_slot_reg  <= voice_slot_next;
            voice_step_reg  <= voice_step_next;
        end
    end

    // gather the output bytes; voice 0 starts the transaction from silence
    always_comb
    begin
        for (int i = 0; i < OUT_VOICES; i++)
        begin
            acc_next[i] = (p2_op_reg.voice == '0) ? SILENCE : acc_reg[i];
            if (32'(p2_op_reg.voice) == i)
            begin
                acc_next[i] = tick_byte;
            end
        end
    end

    always_comb
    begin
        active = '0;
        for (int i = 0; i < VOICES; i++)
        begin
            active = active + CNT_BITS'(voice_en_next[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (p2_valid_reg && p2_tick)
        begin
            acc_reg <= acc_next;
        end
    end

    assign res_push                   = p2_valid_reg && p2_tick && p2_op_reg.last;
    assign res_push_data.voice_a      = acc_next[0];
    assign res_push_data.voice_b      = acc_next[1];
    assign res_push_data.voice_c      = acc_next[2];
    assign res_push_data.voice_d      = acc_next[3];
    assign res_push_data.active_count = 3'(active);

    fvsp_result_queue u_result_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_push_data),
        .valid     (res_valid),
        .ready     (res_ready),
        .data      (res)
    );

    a_voice_interlock: assert property (@(posedge clk) disable iff (!rst_n)
        (p1_valid_reg && p2_valid_reg && p1_op_reg.writes_voice && p2_op_reg.writes_voice)
        |-> (p1_op_reg.voice != p2_op_reg.voice))
        else $error("two ops in flight write the same voice");

    a_push_reserved: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (reserved_reg != 2'd0))
        else $error("tick result without a reserved queue entry");

    a_tick_voice_range: assert property (@(posedge clk) disable iff (!rst_n)
        (iss_go && iss_tick) |-> (32'(vidx_reg) < VOICES))
        else $error("tick issued past the last voice");

endmodule
